// ===== rtl/bbfol_pkg.sv =====
// Shared types and constants for the bounded best-first open list.
package bbfol_pkg;

  localparam int SLOTS    = 16;
  localparam int FEATURES = 64;

  localparam int SUBSET_W = 64;
  localparam int COST_W   = 32;
  localparam int OCC_W    = 5;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_RAW_W = $clog2(SLOTS + 1);
  localparam int CNT_W = (CNT_RAW_W > OCC_W) ? CNT_RAW_W : OCC_W;

  localparam logic [COST_W-1:0] EMPTY_KEY = '1;
  localparam logic [COST_W-1:0] MAX_KEY   = EMPTY_KEY - COST_W'(1);

  localparam logic [SUBSET_W-1:0] FEAT_MASK =
    (FEATURES >= SUBSET_W) ? '1 : ((SUBSET_W'(1) << FEATURES) - SUBSET_W'(1));

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SUBSET_W-1:0] subset_in;
    logic [COST_W-1:0]   cost_in;
  } req_t;

  typedef struct packed {
    logic [SUBSET_W-1:0] subset_out;
    logic [COST_W-1:0]   cost_out;
    logic                was_empty;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/bbfol_ctrl.sv =====
// Sequencer for the open list: accept, slot scan, drain, commit.
module bbfol_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bbfol_pkg::status_t status,
  output bbfol_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.read   = (state == S_READ);
    cmd.commit = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_READ;
            busy  <= 1'b1;
          end
        end
        S_READ: begin
          if (status.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bbfol_dp.sv =====
// Datapath: slot memories, scan compare, count and result register.
module bbfol_dp (
  input  logic               clk,
  input  logic               rst,
  input  bbfol_pkg::req_t    req,
  input  bbfol_pkg::cmd_t    cmd,
  output bbfol_pkg::status_t status,
  output bbfol_pkg::rsp_t    rsp
);

  logic [bbfol_pkg::COST_W-1:0]   cost_mem   [bbfol_pkg::SLOTS];
  logic [bbfol_pkg::SUBSET_W-1:0] subset_mem [bbfol_pkg::SLOTS];
  logic [bbfol_pkg::SLOTS-1:0]    valid;

  bbfol_pkg::req_t req_q;
  logic [bbfol_pkg::IDX_W-1:0]    rd_idx;
  logic [bbfol_pkg::CNT_W-1:0]    count;
  logic [bbfol_pkg::CNT_W-1:0]    count_next;

  // read stage
  logic                           data_vld;
  logic [bbfol_pkg::IDX_W-1:0]    data_idx;
  logic [bbfol_pkg::COST_W-1:0]   data_cost;
  logic [bbfol_pkg::SUBSET_W-1:0] data_subset;
  logic                           data_live;
  logic [bbfol_pkg::COST_W-1:0]   eff_cost;

  // running best
  logic [bbfol_pkg::IDX_W-1:0]    best_idx;
  logic [bbfol_pkg::COST_W-1:0]   best_cost;
  logic [bbfol_pkg::SUBSET_W-1:0] pick_subset;
  logic                           take;

  logic                           is_pop;
  logic                           list_empty;
  logic [bbfol_pkg::COST_W-1:0]   ins_cost;

  assign status.scan_last = (rd_idx == bbfol_pkg::IDX_W'(bbfol_pkg::SLOTS - 1));

  assign is_pop     = (req_q.action == bbfol_pkg::ACT_POP);
  assign list_empty = (count == '0);
  assign ins_cost   = (req_q.cost_in == bbfol_pkg::EMPTY_KEY) ? bbfol_pkg::MAX_KEY
                                                              : req_q.cost_in;

  // an empty slot reads as the reserved key
  assign eff_cost = data_live ? data_cost : bbfol_pkg::EMPTY_KEY;

  // strict compare keeps the lowest index on ties
  always_comb begin
    if (data_idx == '0) begin
      take = 1'b1;
    end else if (is_pop) begin
      take = (eff_cost < best_cost);
    end else begin
      take = (eff_cost > best_cost);
    end
  end

  always_comb begin
    count_next = count;
    if (is_pop) begin
      if (!list_empty) count_next = count - bbfol_pkg::CNT_W'(1);
    end else if (count < bbfol_pkg::CNT_W'(bbfol_pkg::SLOTS)) begin
      count_next = count + bbfol_pkg::CNT_W'(1);
    end
  end

  // memories: one read port for the scan, one write port at commit
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      data_cost   <= cost_mem[rd_idx];
      data_subset <= subset_mem[rd_idx];
    end
    if (cmd.commit && !is_pop) begin
      cost_mem[best_idx]   <= ins_cost;
      subset_mem[best_idx] <= req_q.subset_in & bbfol_pkg::FEAT_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req;
      rd_idx <= '0;
    end else if (cmd.read) begin
      rd_idx <= rd_idx + bbfol_pkg::IDX_W'(1);
    end
    if (cmd.read) begin
      data_idx  <= rd_idx;
      data_live <= valid[rd_idx];
    end
    if (data_vld && take) begin
      best_idx    <= data_idx;
      best_cost   <= eff_cost;
      pick_subset <= data_subset;
    end
    if (cmd.commit) begin
      if (!is_pop) begin
        rsp.subset_out <= '0;
        rsp.cost_out   <= bbfol_pkg::EMPTY_KEY;
        rsp.was_empty  <= 1'b0;
      end else if (list_empty) begin
        rsp.subset_out <= '0;
        rsp.cost_out   <= bbfol_pkg::EMPTY_KEY;
        rsp.was_empty  <= 1'b1;
      end else begin
        rsp.subset_out <= pick_subset;
        rsp.cost_out   <= best_cost;
        rsp.was_empty  <= 1'b0;
      end
      rsp.occupancy <= count_next[bbfol_pkg::OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      data_vld <= 1'b0;
    end else begin
      data_vld <= cmd.read;
      if (cmd.commit) begin
        count <= count_next;
        if (!is_pop) begin
          valid[best_idx] <= 1'b1;
        end else if (!list_empty) begin
          valid[best_idx] <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/bounded_best_first_open_list.sv =====
// Top level of the bounded best-first open list.
//
//  channel   ports               transfer when
//  request   start, busy, req    start high while busy low
//  result    done, rsp           done high (one cycle, no back-pressure)
//
// Every item goes from accept to the done strobe in order: a scan of all slots
// through the single read port of the slot memories, a drain state to finish the
// last compare, and a commit state to write back.
// busy falls with the done strobe, so the next item can start in that cycle.
// Reset (rst, synchronous) clears the slot valid bits and the count; no
// clearing pass is needed. The result side never stalls.
module bounded_best_first_open_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bbfol_pkg::req_t req,
  output logic            busy,
  output logic            done,
  output bbfol_pkg::rsp_t rsp
);

  bbfol_pkg::cmd_t    cmd;
  bbfol_pkg::status_t status;

  bbfol_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bbfol_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

// ===== rtl/bbfol_checker.sv =====
// Port-level checks for the open list, bound to the top level.
module bbfol_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input bbfol_pkg::req_t req,
  input logic            busy,
  input logic            done,
  input bbfol_pkg::rsp_t rsp
);

  // an accepted transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after accept");

  // busy only rises from an accept
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // results come one at a time with the block released
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("done strobe overlapped busy or repeated");

  // an empty pop reports an empty list and the reserved key
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && rsp.was_empty |->
      rsp.occupancy == '0 && rsp.cost_out == bbfol_pkg::EMPTY_KEY && rsp.subset_out == '0)
    else $error("empty pop result malformed");

  // occupancy never exceeds the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.occupancy <= bbfol_pkg::OCC_W'(bbfol_pkg::SLOTS))
    else $error("occupancy out of range");

endmodule

bind bounded_best_first_open_list bbfol_checker u_bbfol_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for the bounded best-first open list: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_ITEMS = 1625;
  localparam int TAIL_CYCLES = 2 * (bbfol_pkg::SLOTS + 2);

  typedef struct {
    logic                           act;
    logic [bbfol_pkg::SUBSET_W-1:0] bits;
    logic [bbfol_pkg::COST_W-1:0]   key;
    int                             reps;
    bit                             has_exp;
    bbfol_pkg::rsp_t                exp;
  } plan_row_t;

  logic clk;
  logic rst;
  logic start;
  bbfol_pkg::req_t req;
  logic busy;
  logic done;
  bbfol_pkg::rsp_t rsp;

  // model state of the list
  logic [bbfol_pkg::COST_W-1:0]   slot_key [bbfol_pkg::SLOTS];
  logic [bbfol_pkg::SUBSET_W-1:0] slot_bits[bbfol_pkg::SLOTS];
  int                             live_count;

  bbfol_pkg::rsp_t exp_replies[$];
  bit              row_has_exp;
  bbfol_pkg::rsp_t row_exp;
  bit              no_gaps;
  int              bad_replies;
  int              idle_cycles;

  bounded_best_first_open_list dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bbfol_pkg::rsp_t reply(logic [bbfol_pkg::SUBSET_W-1:0] bits,
                                            logic [bbfol_pkg::COST_W-1:0] key,
                                            logic empty, int occ);
    bbfol_pkg::rsp_t r;
    r.subset_out = bits;
    r.cost_out   = key;
    r.was_empty  = empty;
    r.occupancy  = bbfol_pkg::OCC_W'(occ);
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic act, logic [bbfol_pkg::SUBSET_W-1:0] bits,
                                         logic [bbfol_pkg::COST_W-1:0] key, int reps,
                                         bit has_exp, bbfol_pkg::rsp_t exp);
    plan_row_t p;
    p.act     = act;
    p.bits    = bits;
    p.key     = key;
    p.reps    = reps;
    p.has_exp = has_exp;
    p.exp     = exp;
    return p;
  endfunction

  // Insert replaces the worst slot (lowest index on ties); pop takes the best.
  task automatic apply_list_op(input bbfol_pkg::req_t r, output bbfol_pkg::rsp_t e);
    int pick;
    logic [bbfol_pkg::COST_W-1:0] key;
    pick = 0;
    e = reply('0, bbfol_pkg::EMPTY_KEY, 1'b0, 0);
    if (r.action == bbfol_pkg::ACT_INSERT) begin
      key = (r.cost_in == bbfol_pkg::EMPTY_KEY) ? bbfol_pkg::MAX_KEY : r.cost_in;
      for (int i = 1; i < bbfol_pkg::SLOTS; i++)
        if (slot_key[i] > slot_key[pick]) pick = i;
      if (live_count < bbfol_pkg::SLOTS) live_count++;
      slot_key[pick]  = key;
      slot_bits[pick] = r.subset_in & bbfol_pkg::FEAT_MASK;
    end else if (live_count == 0) begin
      e.was_empty = 1'b1;
    end else begin
      for (int i = 1; i < bbfol_pkg::SLOTS; i++)
        if (slot_key[i] < slot_key[pick]) pick = i;
      e.subset_out   = slot_bits[pick];
      e.cost_out     = slot_key[pick];
      slot_key[pick] = bbfol_pkg::EMPTY_KEY;
      live_count--;
    end
    e.occupancy = bbfol_pkg::OCC_W'(live_count);
  endtask

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic issue(input bbfol_pkg::req_t r, input bit has_e, input bbfol_pkg::rsp_t e);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    while (busy) @(negedge clk);
    repeat (gap) @(negedge clk);
    start       <= 1'b1;
    req         <= r;
    row_has_exp <= has_e;
    row_exp     <= e;
    // busy is low here, so the next rising edge takes the transfer
    @(negedge clk);
    start       <= 1'b0;
  endtask

  always @(posedge clk) begin
    bbfol_pkg::rsp_t want;
    bbfol_pkg::rsp_t got;
    if (!rst) begin
      if (done) begin
        got = rsp;
        if (exp_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("unexpected result: subset=%h cost=%h empty=%b occ=%0d",
                     got.subset_out, got.cost_out, got.was_empty, got.occupancy);
        end else begin
          want = exp_replies.pop_front();
          if (got.subset_out !== want.subset_out || got.cost_out !== want.cost_out ||
              got.was_empty !== want.was_empty || got.occupancy !== want.occupancy) begin
            bad_replies++;
            if (bad_replies <= 10) begin
              $display("mismatch exp: subset=%h cost=%h empty=%b occ=%0d",
                       want.subset_out, want.cost_out, want.was_empty, want.occupancy);
              $display("         got: subset=%h cost=%h empty=%b occ=%0d",
                       got.subset_out, got.cost_out, got.was_empty, got.occupancy);
            end
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(req, want);
        if (row_has_exp) want = row_exp;
        exp_replies.insert(exp_replies.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t plan[10];
    bbfol_pkg::req_t r;
    bbfol_pkg::rsp_t none;
    int ins_pct;
    int pick_cost;

    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    row_has_exp = 1'b0;
    row_exp     = '0;
    no_gaps     = 1'b0;
    bad_replies = 0;
    idle_cycles = 0;
    live_count  = 0;
    for (int i = 0; i < bbfol_pkg::SLOTS; i++) begin
      slot_key[i]  = bbfol_pkg::EMPTY_KEY;
      slot_bits[i] = '0;
    end
    none = '0;

    plan[0] = plan_row(bbfol_pkg::ACT_POP, '0, '0, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b1, 0));
    plan[1] = plan_row(bbfol_pkg::ACT_INSERT, '1, '0, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b0, 1));
    // cost at the empty marker is saturated one below it
    plan[2] = plan_row(bbfol_pkg::ACT_INSERT, '0, bbfol_pkg::EMPTY_KEY, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b0, 2));
    plan[3] = plan_row(bbfol_pkg::ACT_INSERT, 64'h8000_0000_0000_0000,
                       bbfol_pkg::MAX_KEY, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b0, 3));
    plan[4] = plan_row(bbfol_pkg::ACT_POP, '0, '0, 1, 1, reply('1, '0, 1'b0, 2));
    // tie at MAX_KEY: lower slot first
    plan[5] = plan_row(bbfol_pkg::ACT_POP, '1, '1, 1, 1,
                       reply('0, bbfol_pkg::MAX_KEY, 1'b0, 1));
    plan[6] = plan_row(bbfol_pkg::ACT_POP, '0, '0, 1, 1,
                       reply(64'h8000_0000_0000_0000, bbfol_pkg::MAX_KEY, 1'b0, 0));
    plan[7] = plan_row(bbfol_pkg::ACT_POP, '0, '0, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b1, 0));
    // fill to capacity, then insert into a full list
    plan[8] = plan_row(bbfol_pkg::ACT_INSERT, 64'h0123_4567_89ab_cdef, 32'd100,
                       bbfol_pkg::SLOTS, 0, none);
    plan[9] = plan_row(bbfol_pkg::ACT_INSERT, 64'h5a5a_5a5a_a5a5_a5a5, 32'd5, 1, 1,
                       reply('0, bbfol_pkg::EMPTY_KEY, 1'b0, bbfol_pkg::SLOTS));

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      for (int n = 0; n < plan[k].reps; n++) begin
        r.action    = plan[k].act;
        r.subset_in = plan[k].bits ^ bbfol_pkg::SUBSET_W'(n);
        r.cost_in   = plan[k].key + bbfol_pkg::COST_W'(7 * n);
        issue(r, plan[k].has_exp, plan[k].exp);
      end
    end

    ins_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // switch at random between fill, drain and balanced phases to reach full and empty often
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
      end
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RAND_ITEMS / 2) begin
        while (exp_replies.size() != 0) @(negedge clk);
      end
      r.action    = ($urandom_range(0, 99) < ins_pct) ? bbfol_pkg::ACT_INSERT
                                                      : bbfol_pkg::ACT_POP;
      r.subset_in = {$urandom, $urandom};
      pick_cost   = $urandom_range(0, 9);
      if (pick_cost < 4)
        r.cost_in = bbfol_pkg::COST_W'($urandom_range(0, 7));
      else if (pick_cost == 4)
        case ($urandom_range(0, 2))
          0: r.cost_in = '0;
          1: r.cost_in = bbfol_pkg::MAX_KEY;
          default: r.cost_in = bbfol_pkg::EMPTY_KEY;
        endcase
      else
        r.cost_in = $urandom;
      issue(r, 1'b0, none);
    end

    row_has_exp <= 1'b0;
    while (exp_replies.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (bad_replies == 0 && exp_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bbfol_pkg.sv
rtl/bbfol_ctrl.sv
rtl/bbfol_dp.sv
rtl/bounded_best_first_open_list.sv
rtl/bbfol_checker.sv
tb/tb_top.sv
